// ===== design/xs1024_pkg.sv =====
// Shared types, constants and mixing functions for the xorshift1024* generator.
package xs1024_pkg;

    localparam logic [63:0] DRAW_MULT = 64'd1181783497276652981;
    localparam logic [63:0] SEED_MULT = 64'd2685821657736338717;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_LL,
        MUL_HL,
        MUL_LH
    } t_mul_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SEED_RUN,
        S_MUL_LL,
        S_MUL_HL,
        S_MUL_LH,
        S_OUT,
        S_SEED_WR
    } t_state;

    typedef struct packed {
        logic    rd_issue;
        logic    draw_upd;
        logic    seed_load;
        logic    seed_run;
        t_mul_op mul_op;
        logic    seed_wr;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic seed_last;
        logic out_free;
    } t_dp_stat;

    function automatic logic [63:0] seeder_mix(input logic [63:0] x);
        logic [63:0] v;
        v = x;
        v = v ^ (v >> 12);
        v = v ^ (v << 25);
        v = v ^ (v >> 27);
        return v;
    endfunction

    function automatic logic [63:0] ring_mix(input logic [63:0] s0_in, input logic [63:0] s1_in);
        logic [63:0] s0;
        logic [63:0] s1;
        s0 = s0_in;
        s1 = s1_in;
        s1 = s1 ^ (s1 << 31);
        s1 = s1 ^ (s1 >> 11);
        s0 = s0 ^ (s0 >> 30);
        return s0 ^ s1;
    endfunction

endpackage

// ===== design/xs1024_ctrl.sv =====
// Sequencer for draw and reseed transfers of the xorshift1024* generator.
module xs1024_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_kind,
    output logic                  o_ready,
    input  xs1024_pkg::t_dp_stat  i_stat,
    output xs1024_pkg::t_dp_cmd   o_cmd
);
    import xs1024_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_is_seed;
    logic   n_is_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_is_seed <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_seed <= n_is_seed;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_is_seed    = r_is_seed;
        o_cmd        = '0;
        o_cmd.mul_op = MUL_NONE;
        o_ready      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_is_seed = i_kind;
                    if (i_kind) begin
                        o_cmd.seed_load = 1'b1;
                        n_state         = S_SEED_RUN;
                    end else begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.draw_upd = 1'b1;
                n_state        = S_MUL_LL;
            end
            S_SEED_RUN: begin
                o_cmd.seed_run = 1'b1;
                n_state        = S_MUL_LL;
            end
            S_MUL_LL: begin
                o_cmd.mul_op = MUL_LL;
                n_state      = S_MUL_HL;
            end
            S_MUL_HL: begin
                o_cmd.mul_op = MUL_HL;
                n_state      = S_MUL_LH;
            end
            S_MUL_LH: begin
                o_cmd.mul_op = MUL_LH;
                n_state      = r_is_seed ? S_SEED_WR : S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SEED_WR: begin
                o_cmd.seed_wr = 1'b1;
                n_state       = i_stat.seed_last ? S_IDLE : S_SEED_RUN;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== design/xs1024_dp.sv =====
// Datapath: state ring memory, pointer, seeder, shared 32x32 multiplier, output register.
module xs1024_dp #(
    parameter int RING_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [63:0]           i_seed_value,
    input  xs1024_pkg::t_dp_cmd   i_cmd,
    output xs1024_pkg::t_dp_stat  o_stat,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [63:0]           o_random_value
);
    import xs1024_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);

    logic [63:0]           r_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_valid;
    logic [63:0]           r_rd0;
    logic [63:0]           r_rd1;
    logic                  r_v0;
    logic                  r_v1;
    logic [PTR_W-1:0]      r_ptr;
    logic [PTR_W-1:0]      r_cnt;
    logic [63:0]           r_seed;
    logic [63:0]           r_a;
    logic                  r_csel;
    logic [63:0]           r_acc;
    logic [63:0]           r_out;
    logic                  r_out_valid;

    logic [PTR_W-1:0]      w_nxt;
    logic [PTR_W-1:0]      w_cnt_nxt;
    logic [63:0]           w_mix;
    logic [63:0]           w_seed_mix;
    logic                  w_wr_en;
    logic [PTR_W-1:0]      w_wr_addr;
    logic [63:0]           w_wr_data;
    logic [63:0]           w_const;
    logic [31:0]           w_mx;
    logic [31:0]           w_my;
    logic [63:0]           w_prod;

    assign w_nxt      = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
    assign w_cnt_nxt  = (r_cnt == LAST_IDX) ? '0 : r_cnt + 1'b1;
    assign w_mix      = ring_mix(r_v0 ? r_rd0 : 64'd0, r_v1 ? r_rd1 : 64'd0);
    assign w_seed_mix = seeder_mix(r_seed);
    assign w_wr_en    = i_cmd.draw_upd | i_cmd.seed_wr;
    assign w_wr_addr  = i_cmd.draw_upd ? w_nxt : r_cnt;
    assign w_wr_data  = i_cmd.draw_upd ? w_mix : r_acc;
    assign w_const    = r_csel ? SEED_MULT : DRAW_MULT;

    always_comb begin
        case (i_cmd.mul_op)
            MUL_HL: begin
                w_mx = r_a[63:32];
                w_my = w_const[31:0];
            end
            MUL_LH: begin
                w_mx = r_a[31:0];
                w_my = w_const[63:32];
            end
            default: begin
                w_mx = r_a[31:0];
                w_my = w_const[31:0];
            end
        endcase
    end

    assign w_prod = 64'(w_mx) * 64'(w_my);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_issue) begin
            r_rd0 <= r_mem[r_ptr];
            r_rd1 <= r_mem[w_nxt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_wr_en) begin
            r_valid[w_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_v0 <= r_valid[r_ptr];
            r_v1 <= r_valid[w_nxt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_cnt  <= '0;
            r_seed <= '0;
        end else begin
            if (i_cmd.draw_upd) begin
                r_ptr <= w_nxt;
            end
            if (i_cmd.seed_load) begin
                r_seed <= i_seed_value;
                r_cnt  <= '0;
            end else if (i_cmd.seed_run) begin
                r_seed <= w_seed_mix;
            end
            if (i_cmd.seed_wr) begin
                r_cnt <= w_cnt_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.draw_upd) begin
            r_a    <= w_mix;
            r_csel <= 1'b0;
        end else if (i_cmd.seed_run) begin
            r_a    <= w_seed_mix;
            r_csel <= 1'b1;
        end
        case (i_cmd.mul_op)
            MUL_LL:         r_acc <= w_prod;
            MUL_HL, MUL_LH: r_acc[63:32] <= r_acc[63:32] + w_prod[31:0];
            default:        r_acc <= r_acc;
        endcase
        if (i_cmd.out_load) begin
            r_out <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.seed_last = (r_cnt == LAST_IDX);
    assign o_stat.out_free  = !r_out_valid || i_ready;
    assign o_valid          = r_out_valid;
    assign o_random_value   = r_out;

endmodule

// ===== design/xorshift1024star_prng.sv =====
// Top level of the xorshift1024* generator with xorshift64* reseeding.
// Draw: S_READ, S_MUL_LL, S_MUL_HL, S_MUL_LH, then S_OUT sets o_valid; a new item is taken only back in S_IDLE.
// Reseed: 16 fills, each through S_SEED_RUN, S_MUL_LL, S_MUL_HL, S_MUL_LH and S_SEED_WR; no result.
// Per-item cost is set by the shared 32x32 multiplier, three passes per 64-bit product.
// A waiting result does not block the next transfer; the next draw then waits in S_OUT and takes no transfer.
// Reset (synchronous, active low) clears ring valid bits, pointer and seeder: draws return zero.
module xorshift1024star_prng #(
    parameter int RING_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [63:0] i_seed_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_random_value
);
    import xs1024_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    xs1024_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    xs1024_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_value   (i_seed_value),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_random_value (o_random_value)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_valid || i_ready))
        else $error("output register loaded over a pending result");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("item taken while previous one still in work");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.seed_wr && w_cmd.draw_upd))
        else $error("two ring writes in one cycle");

    a_out_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.mul_op == MUL_LH) |=> !w_cmd.rd_issue)
        else $error("read issued right after product completion");

endmodule
